/* hdl/palette_allocate_or_nearest_defines.svh */
// Assertion macros for the palette allocator.
// Included by pal_dp, which carries the concurrent checks; needs clk_i and rst_ni in scope.
`ifndef PALETTE_ALLOCATE_OR_NEAREST_DEFINES_SVH
`define PALETTE_ALLOCATE_OR_NEAREST_DEFINES_SVH

// Checked on every clock edge outside reset.
`define PAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define PAL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/pal_pkg.sv */
// Shared types, codes and the color distance function for the palette allocator.
// No dependencies.
package pal_pkg;

  localparam int unsigned PAL_DEPTH = 256;

  localparam int unsigned RED_SHIFT   = 11;
  localparam int unsigned GREEN_SHIFT = 5;
  localparam logic [4:0]  FIVE_MASK   = 5'h1F;
  localparam logic [5:0]  SIX_MASK    = 6'h3F;

  localparam int unsigned DIST_W = 13;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [1:0] OUTCOME_MATCH   = 2'd0;
  localparam logic [1:0] OUTCOME_APPEND  = 2'd1;
  localparam logic [1:0] OUTCOME_NEAREST = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } pal_state_e;

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } pal_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } pal_sts_t;

  function automatic logic [DIST_W-1:0] pal_dist(input logic [15:0] a, input logic [15:0] b);
    logic [5:0]  ra, rb, ga, gb, ba, bb;
    logic [5:0]  dr, dg, db;
    logic [11:0] sr, sg, sb;
    ra = {1'b0, a[RED_SHIFT +: 5] & FIVE_MASK};
    rb = {1'b0, b[RED_SHIFT +: 5] & FIVE_MASK};
    ga = a[GREEN_SHIFT +: 6] & SIX_MASK;
    gb = b[GREEN_SHIFT +: 6] & SIX_MASK;
    ba = {1'b0, a[4:0] & FIVE_MASK};
    bb = {1'b0, b[4:0] & FIVE_MASK};
    dr = (ra > rb) ? (ra - rb) : (rb - ra);
    dg = (ga > gb) ? (ga - gb) : (gb - ga);
    db = (ba > bb) ? (ba - bb) : (bb - ba);
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  endfunction

endpackage

/* hdl/pal_ctrl.sv */
// Controller state machine for the palette allocator.
// Depends on pal_pkg; drives pal_dp through the command struct.
module pal_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pal_pkg::pal_sts_t sts_i,
  output pal_pkg::pal_cmd_t cmd_o
);
  import pal_pkg::*;

  pal_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/pal_dp.sv */
// Datapath for the palette allocator: palette memory, scan pipeline, counters, output register.
// Depends on pal_pkg and palette_allocate_or_nearest_defines.svh; commanded by pal_ctrl.
`include "palette_allocate_or_nearest_defines.svh"

module pal_dp #(
  parameter int unsigned PALETTE_DEPTH = pal_pkg::PAL_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       color_i,
  input  pal_pkg::pal_cmd_t cmd_i,
  output pal_pkg::pal_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        index_o,
  output logic [1:0]        outcome_o,
  output logic [8:0]        entries_used_o,
  output logic [31:0]       overflow_total_o
);
  import pal_pkg::*;

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(PALETTE_DEPTH);

  logic [15:0]       mem [PALETTE_DEPTH];
  logic [15:0]       color_q;
  logic [15:0]       rdata_q;
  logic [CW-1:0]     used_q;
  logic [CW-1:0]     rd_addr_q;
  logic [AW-1:0]     rd_idx_q;
  logic              rdv_q;
  logic              found_q;
  logic [AW-1:0]     match_idx_q;
  logic [DIST_W-1:0] best_q;
  logic [AW-1:0]     best_idx_q;
  logic [31:0]       ovf_q;
  logic              out_valid_q;
  logic [7:0]        index_q;
  logic [1:0]        outcome_q;
  logic [8:0]        entries_q;
  logic [31:0]       ovf_out_q;

  logic              issue;
  logic              append;
  logic              nearest;
  logic [DIST_W-1:0] cand_dist;

  assign issue     = cmd_i.scan && (rd_addr_q < used_q);
  assign append    = cmd_i.finish && !found_q && (used_q < DEPTH_C);
  assign nearest   = cmd_i.finish && !found_q && (used_q >= DEPTH_C);
  assign cand_dist = pal_dist(color_q, rdata_q);

  assign sts_o.scan_done = !issue && !rdv_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (append) mem[used_q[AW-1:0]] <= color_q;
    if (issue) rdata_q <= mem[rd_addr_q[AW-1:0]];
    if (issue) rd_idx_q <= rd_addr_q[AW-1:0];
    if (cmd_i.start) color_q <= color_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q   <= '0;
      rdv_q       <= 1'b0;
      found_q     <= 1'b0;
      match_idx_q <= '0;
      best_q      <= DIST_MAX;
      best_idx_q  <= '0;
    end else if (cmd_i.start) begin
      rd_addr_q   <= '0;
      rdv_q       <= 1'b0;
      found_q     <= 1'b0;
      match_idx_q <= '0;
      best_q      <= DIST_MAX;
      best_idx_q  <= '0;
    end else begin
      rdv_q <= issue;
      if (issue) rd_addr_q <= rd_addr_q + 1'b1;
      if (rdv_q) begin
        if (!found_q && (rdata_q == color_q)) begin
          found_q     <= 1'b1;
          match_idx_q <= rd_idx_q;
        end
        if (cand_dist < best_q) begin
          best_q     <= cand_dist;
          best_idx_q <= rd_idx_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      ovf_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (append) used_q <= used_q + 1'b1;
      if (nearest) ovf_q <= ovf_q + 32'd1;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (found_q) begin
        index_q   <= 8'(match_idx_q);
        outcome_q <= OUTCOME_MATCH;
        entries_q <= 9'(used_q);
        ovf_out_q <= ovf_q;
      end else if (append) begin
        index_q   <= 8'(used_q);
        outcome_q <= OUTCOME_APPEND;
        entries_q <= 9'(used_q + 1'b1);
        ovf_out_q <= ovf_q;
      end else begin
        index_q   <= 8'(best_idx_q);
        outcome_q <= OUTCOME_NEAREST;
        entries_q <= 9'(used_q);
        ovf_out_q <= ovf_q + 32'd1;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign index_o          = index_q;
  assign outcome_o        = outcome_q;
  assign entries_used_o   = entries_q;
  assign overflow_total_o = ovf_out_q;

  `PAL_ASSERT_ALWAYS(a_used_bound, !rst_ni || (used_q <= DEPTH_C), "used count above palette depth")
  `PAL_ASSERT(a_read_in_use, rdv_q |-> (CW'(rd_idx_q) < used_q), "read of an entry not in use")
  `PAL_ASSERT(a_match_in_use, found_q |-> (CW'(match_idx_q) < used_q), "match index not in use")
  `PAL_ASSERT(a_append_grows, append |=> (used_q == $past(used_q) + 1'b1),
              "append did not grow the palette")

endmodule

/* hdl/palette_allocate_or_nearest.sv */
// Each accepted transaction is compared with every palette entry in use, one entry per cycle from the
// palette memory read port; the color is then matched, appended or mapped to the nearest entry and the
// result registered, once the previous result has been taken on out_ready_i. No new transaction is
// accepted until the result is registered; in_ready_o is high only in the idle state.
// Reset (rst_ni, asynchronous, active low) empties the palette and clears the overflow count;
// palette memory contents are not cleared and no clearing pass runs.
module palette_allocate_or_nearest #(
  parameter int unsigned PALETTE_DEPTH = pal_pkg::PAL_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] color_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  index_o,
  output logic [1:0]  outcome_o,
  output logic [8:0]  entries_used_o,
  output logic [31:0] overflow_total_o
);
  import pal_pkg::*;

  pal_cmd_t cmd;
  pal_sts_t sts;

  pal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pal_dp #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .color_i          (color_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .index_o          (index_o),
    .outcome_o        (outcome_o),
    .entries_used_o   (entries_used_o),
    .overflow_total_o (overflow_total_o)
  );

endmodule
